FILE: sv/vad_pkg.sv
package vad_pkg;

	localparam int COMP_BITS = 16;
	// |a.b| and |a|^2 both stay below 2^(2*COMP_BITS)
	localparam int NORM_W = 2 * COMP_BITS;
	localparam int DOT_W = 2 * COMP_BITS + 1;
	localparam int SQ_W = 2 * COMP_BITS - 1;
	localparam int PROD_W = 2 * NORM_W;
	localparam int SCALE_W = 16;
	localparam int L_W = PROD_W + SCALE_W;
	localparam int Q_W = 7;
	localparam int M2_W = 16;
	localparam int THR_W = 21;
	localparam int SEARCH_STEPS = Q_W;
	localparam logic [SCALE_W-1:0] COS_SCALE_SQ = 16'd40000;
	localparam logic [Q_W-1:0] Q_MAX = 7'd100;
	localparam logic [7:0] RIGHT_ANGLE = 8'd90;

	typedef struct packed {
		logic signed [COMP_BITS-1:0] ax;
		logic signed [COMP_BITS-1:0] ay;
		logic signed [COMP_BITS-1:0] az;
		logic signed [COMP_BITS-1:0] bx;
		logic signed [COMP_BITS-1:0] by_comp;
		logic signed [COMP_BITS-1:0] bz;
	} src_t;

	typedef struct packed {
		logic [7:0] angle_deg;
		logic signed [7:0] cos_hundredths;
	} res_t;

	// one item inside the cosine search
	typedef struct packed {
		logic [L_W-1:0] lhs;
		logic [PROD_W-1:0] nprod;
		logic dneg;
		logic [Q_W-1:0] q;
	} srch_t;

	// sin((i + 0.5) deg) in millionths
	localparam logic [19:0] HALF_SINE [90] = '{
		20'd8727, 20'd26177, 20'd43619, 20'd61049, 20'd78459, 20'd95846, 20'd113203,
		20'd130526, 20'd147809, 20'd165048, 20'd182236, 20'd199368, 20'd216440,
		20'd233445, 20'd250380, 20'd267238, 20'd284015, 20'd300706, 20'd317305,
		20'd333807, 20'd350207, 20'd366501, 20'd382683, 20'd398749, 20'd414693,
		20'd430511, 20'd446198, 20'd461749, 20'd477159, 20'd492424, 20'd507538,
		20'd522499, 20'd537300, 20'd551937, 20'd566406, 20'd580703, 20'd594823,
		20'd608761, 20'd622515, 20'd636078, 20'd649448, 20'd662620, 20'd675590,
		20'd688355, 20'd700909, 20'd713250, 20'd725374, 20'd737277, 20'd748956,
		20'd760406, 20'd771625, 20'd782608, 20'd793353, 20'd803857, 20'd814116,
		20'd824126, 20'd833886, 20'd843391, 20'd852640, 20'd861629, 20'd870356,
		20'd878817, 20'd887011, 20'd894934, 20'd902585, 20'd909961, 20'd917060,
		20'd923880, 20'd930418, 20'd936672, 20'd942641, 20'd948324, 20'd953717,
		20'd958820, 20'd963630, 20'd968148, 20'd972370, 20'd976296, 20'd979925,
		20'd983255, 20'd986286, 20'd989016, 20'd991445, 20'd993572, 20'd995396,
		20'd996917, 20'd998135, 20'd999048, 20'd999657, 20'd999962
	};

	// degrees away from 90 for a cosine of q hundredths (128-entry table)
	function automatic logic [Q_W-1:0] sine_steps(input logic [Q_W-1:0] q);
		logic [THR_W-1:0] thr;
		logic [Q_W-1:0] s;
		thr = THR_W'(q) * THR_W'(10000);
		s = '0;
		for (int i = 0; i < 90; i++) begin
			if (THR_W'(HALF_SINE[i]) <= thr) begin
				s = s + 1'b1;
			end
		end
		return s;
	endfunction

	// (2c-1)^2, a 128-entry table
	function automatic logic [M2_W-1:0] odd_sq(input logic [Q_W-1:0] c);
		logic [M2_W-1:0] m;
		m = M2_W'({c, 1'b0}) - M2_W'(1);
		return M2_W'(m * m);
	endfunction

endpackage

FILE: sv/vad_srch.sv
module vad_srch #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  vad_pkg::srch_t in_d,
	output logic           out_vld,
	output vad_pkg::srch_t out_d
);
	import vad_pkg::*;

	logic [Q_W-1:0] cand;
	logic [L_W-1:0] rhs;
	logic take;
	logic vld_q;
	srch_t nxt;
	srch_t d_q;

	// one bit of the binary search: keep it if c <= Q_MAX, D != 0 and (200|D|)^2 >= Na*Nb*(2c-1)^2
	assign cand = in_d.q | Q_W'(1 << BIT);
	assign rhs = L_W'(in_d.nprod) * L_W'(odd_sq(cand));
	assign take = (cand <= Q_MAX) && (in_d.lhs != '0) && (in_d.lhs >= rhs);

	always_comb begin
		nxt = in_d;
		nxt.q = take ? cand : in_d.q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign out_d = d_q;

endmodule

FILE: sv/vector_angle_degrees.sv
// Channel | Direction | Handshake              | Payload
// src     | in        | src_valid / src_stall  | src_data (ax ay az bx by_comp bz)
// res     | out       | res_valid / res_stall  | res_data (angle_deg cos_hundredths)
//
// One transfer in and one out per cycle while res_stall is low.
// Stages: products, sums, |D|^2 and Na*Nb, scaling, seven binary-search
// steps on the cosine (one 64x16 multiply each), then the degree lookup.
// arst_n clears only the valid bits; data registers are not reset.
// A stage moves when it is empty or the next one moves, so bubbles close
// up and res_stall reaches src_stall the same cycle.
module vector_angle_degrees (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	input  vad_pkg::src_t src_data,
	output logic          res_valid,
	input  logic          res_stall,
	output vad_pkg::res_t res_data
);
	import vad_pkg::*;

	localparam int NST = 5 + SEARCH_STEPS;

	logic [NST:0] rdy;
	logic [NST-1:0] vld;

	logic signed [COMP_BITS-1:0] a_c [3];
	logic signed [COMP_BITS-1:0] b_c [3];

	// stage 1: per-component products
	logic vld_s1;
	logic signed [2*COMP_BITS-1:0] p_s1 [3];
	logic [SQ_W-1:0] sqa_s1 [3];
	logic [SQ_W-1:0] sqb_s1 [3];
	// stage 2: dot product and squared norms
	logic vld_s2;
	logic signed [DOT_W-1:0] dot_s2;
	logic [NORM_W-1:0] na_s2;
	logic [NORM_W-1:0] nb_s2;
	// stage 3
	logic vld_s3;
	logic dneg_s3;
	logic [PROD_W-1:0] dsq_s3;
	logic [PROD_W-1:0] np_s3;
	// stage 4
	logic vld_s4;
	srch_t srch_s4;
	// search chain
	logic srch_vld [SEARCH_STEPS+1];
	srch_t srch_d [SEARCH_STEPS+1];
	// output stage
	logic vld_s12;
	res_t res_s12;

	logic signed [DOT_W-1:0] dot_abs;
	logic neg_fin;
	logic [Q_W-1:0] q_fin;
	logic [Q_W-1:0] s_fin;

	assign a_c[0] = src_data.ax;
	assign a_c[1] = src_data.ay;
	assign a_c[2] = src_data.az;
	assign b_c[0] = src_data.bx;
	assign b_c[1] = src_data.by_comp;
	assign b_c[2] = src_data.bz;

	// ready chain
	assign vld[0] = vld_s1;
	assign vld[1] = vld_s2;
	assign vld[2] = vld_s3;
	assign vld[3] = vld_s4;
	assign vld[NST-1] = vld_s12;
	assign rdy[NST] = !res_stall;
	for (genvar i = 0; i < NST; i++) begin : g_rdy
		assign rdy[i] = !vld[i] || rdy[i+1];
	end
	assign src_stall = !rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			if (rdy[0]) vld_s1 <= src_valid;
			if (rdy[1]) vld_s2 <= vld_s1;
			if (rdy[2]) vld_s3 <= vld_s2;
			if (rdy[3]) vld_s4 <= vld_s3;
			if (rdy[NST-1]) vld_s12 <= srch_vld[SEARCH_STEPS];
		end
	end

	// products; signed operands, so -2^(n-1) is taken at full magnitude
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= a_c[i] * b_c[i];
				sqa_s1[i] <= SQ_W'((2*COMP_BITS)'(a_c[i]) * (2*COMP_BITS)'(a_c[i]));
				sqb_s1[i] <= SQ_W'((2*COMP_BITS)'(b_c[i]) * (2*COMP_BITS)'(b_c[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			dot_s2 <= DOT_W'(p_s1[0]) + DOT_W'(p_s1[1]) + DOT_W'(p_s1[2]);
			na_s2 <= NORM_W'(sqa_s1[0]) + NORM_W'(sqa_s1[1]) + NORM_W'(sqa_s1[2]);
			nb_s2 <= NORM_W'(sqb_s1[0]) + NORM_W'(sqb_s1[1]) + NORM_W'(sqb_s1[2]);
		end
	end

	assign dot_abs = dot_s2[DOT_W-1] ? -dot_s2 : dot_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			dneg_s3 <= dot_s2[DOT_W-1];
			dsq_s3 <= PROD_W'(dot_abs[NORM_W-1:0]) * PROD_W'(dot_abs[NORM_W-1:0]);
			np_s3 <= PROD_W'(na_s2) * PROD_W'(nb_s2);
		end
	end

	// 40000*D^2 stands for (200|D|)^2 on the left of every search compare
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			srch_s4.lhs <= L_W'(dsq_s3) * L_W'(COS_SCALE_SQ);
			srch_s4.nprod <= np_s3;
			srch_s4.dneg <= dneg_s3;
			srch_s4.q <= '0;
		end
	end

	assign srch_vld[0] = vld_s4;
	assign srch_d[0] = srch_s4;

	// MSB first: step i decides bit (SEARCH_STEPS-1-i) of the cosine
	for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_srch
		vad_srch #(
			.BIT(SEARCH_STEPS - 1 - i)
		) u_srch (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (rdy[4+i]),
			.in_vld (srch_vld[i]),
			.in_d   (srch_d[i]),
			.out_vld(srch_vld[i+1]),
			.out_d  (srch_d[i+1])
		);
		assign vld[4+i] = srch_vld[i+1];
	end

	// a negative cosine that rounds to zero comes out as plain 0 / 90 deg
	assign q_fin = srch_d[SEARCH_STEPS].q;
	assign neg_fin = srch_d[SEARCH_STEPS].dneg && (q_fin != '0);
	assign s_fin = sine_steps(q_fin);

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			res_s12.cos_hundredths <= neg_fin ? -$signed(8'(q_fin)) : $signed(8'(q_fin));
			res_s12.angle_deg <= neg_fin ? RIGHT_ANGLE + 8'(s_fin) : RIGHT_ANGLE - 8'(s_fin);
		end
	end

	assign res_valid = vld_s12;
	assign res_data = res_s12;

`ifndef NO_ASSERTIONS
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall) |=> vld_s1)
		else $error("accepted transfer did not enter stage 1");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.cos_hundredths <= 8'sd100 &&
			res_data.cos_hundredths >= -8'sd100))
		else $error("cosine out of range");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.angle_deg <= 8'd180))
		else $error("angle out of range");
	a_zero_cos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.cos_hundredths == 8'sd0) |-> (res_data.angle_deg == RIGHT_ANGLE))
		else $error("zero cosine without right angle");
`endif

endmodule
